// File: hdl/pse_pkg.sv
// pse_pkg: shared types, codes and sizes of the postfix stack evaluator
// used by pse_alu and postfix_stack_evaluator_unit
`timescale 1ns / 1ps

package pse_pkg;

    localparam int STACK_ENTRIES = 128;
    localparam int DEPTH_W       = $clog2(STACK_ENTRIES + 1);
    localparam int ADDR_W        = $clog2(STACK_ENTRIES);

    localparam int SYM_W         = 8;
    localparam int VAL_W         = 8;
    localparam int STATUS_W      = 2;
    localparam int OUT_TDATA_W   = 16;
    localparam int POW_EXP_W     = 7;
    localparam int DIV_CNT_W     = 4;

    localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CHAR_TIMES = 8'h2A;
    localparam logic [SYM_W-1:0] CHAR_SLASH = 8'h2F;
    localparam logic [SYM_W-1:0] CHAR_CARET = 8'h5E;
    localparam logic [SYM_W-1:0] CHAR_ZERO  = 8'd48;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
    localparam logic [STATUS_W-1:0] ST_COUNT   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd3;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_POW = 3'd4
    } alu_op_t;

    typedef struct packed {
        logic               start;
        alu_op_t            op;
        logic [VAL_W-1:0]   lhs;
        logic [VAL_W-1:0]   rhs;
    } alu_req_t;

    typedef struct packed {
        logic               done;
        logic               fault;
        logic [VAL_W-1:0]   result;
    } alu_rsp_t;

endpackage

// File: hdl/pse_alu.sv
// pse_alu: shared 8-bit arithmetic unit, add/sub/mul straight into the result register,
// iterative restoring divide and square-and-multiply power; uses pse_pkg
`timescale 1ns / 1ps

module pse_alu (
    input  logic               clk,
    input  logic               rst_n,
    input  pse_pkg::alu_req_t  req,
    output pse_pkg::alu_rsp_t  rsp
);
    import pse_pkg::*;

    typedef enum logic [3:0] {
        A_IDLE = 4'b0001,
        A_DIV  = 4'b0010,
        A_POW  = 4'b0100,
        A_DONE = 4'b1000
    } alu_state_t;

    alu_state_t             state_reg, state_next;
    logic [VAL_W-1:0]       result_reg, result_next;
    logic                   fault_reg, fault_next;
    logic [VAL_W-1:0]       dvd_reg, dvd_next;
    logic [VAL_W-1:0]       dvs_reg, dvs_next;
    logic [VAL_W:0]         rem_reg, rem_next;
    logic                   neg_reg, neg_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [VAL_W-1:0]       acc_reg, acc_next;
    logic [VAL_W-1:0]       sq_reg, sq_next;
    logic [POW_EXP_W-1:0]   exp_reg, exp_next;

    logic [VAL_W-1:0]       lhs_mag, rhs_mag;
    logic [VAL_W:0]         rem_shift;
    logic [2*VAL_W-1:0]     mul_full, acc_prod, sq_prod;

    assign lhs_mag   = req.lhs[VAL_W-1] ? (~req.lhs + 1'b1) : req.lhs;
    assign rhs_mag   = req.rhs[VAL_W-1] ? (~req.rhs + 1'b1) : req.rhs;
    assign mul_full  = req.lhs * req.rhs;
    assign acc_prod  = acc_reg * sq_reg;
    assign sq_prod   = sq_reg * sq_reg;
    assign rem_shift = {rem_reg[VAL_W-1:0], dvd_reg[VAL_W-1]};

    always_comb
    begin
        state_next  = state_reg;
        result_next = result_reg;
        fault_next  = fault_reg;
        dvd_next    = dvd_reg;
        dvs_next    = dvs_reg;
        rem_next    = rem_reg;
        neg_next    = neg_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        sq_next     = sq_reg;
        exp_next    = exp_reg;
        case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    fault_next = 1'b0;
                    state_next = A_DONE;
                    case (req.op)
                        OP_ADD: result_next = req.lhs + req.rhs;
                        OP_SUB: result_next = req.lhs - req.rhs;
                        OP_MUL: result_next = mul_full[VAL_W-1:0];
                        OP_DIV:
                        begin
                            if (req.rhs == '0)
                            begin
                                fault_next = 1'b1;
                            end
                            else
                            begin
                                dvd_next   = lhs_mag;
                                dvs_next   = rhs_mag;
                                rem_next   = '0;
                                neg_next   = req.lhs[VAL_W-1] ^ req.rhs[VAL_W-1];
                                cnt_next   = DIV_CNT_W'(VAL_W);
                                state_next = A_DIV;
                            end
                        end
                        OP_POW:
                        begin
                            if (req.rhs[VAL_W-1])
                            begin
                                if (req.lhs == '0)
                                    fault_next = 1'b1;
                                else if (req.lhs == VAL_W'(1))
                                    result_next = VAL_W'(1);
                                else if (req.lhs == '1)
                                    result_next = req.rhs[0] ? '1 : VAL_W'(1);
                                else
                                    result_next = '0;
                            end
                            else
                            begin
                                acc_next   = VAL_W'(1);
                                sq_next    = req.lhs;
                                exp_next   = req.rhs[POW_EXP_W-1:0];
                                state_next = A_POW;
                            end
                        end
                        default: result_next = '0;
                    endcase
                end
            end
            A_DIV:
            begin
                dvd_next = {dvd_reg[VAL_W-2:0], 1'b0};
                if (rem_shift >= {1'b0, dvs_reg})
                begin
                    rem_next    = rem_shift - {1'b0, dvs_reg};
                    result_next = {result_reg[VAL_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next    = rem_shift;
                    result_next = {result_reg[VAL_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    state_next = A_DONE;
                    if (neg_reg)
                        result_next = ~result_next + 1'b1;
                end
            end
            A_POW:
            begin
                if (exp_reg == '0)
                begin
                    result_next = acc_reg;
                    state_next  = A_DONE;
                end
                else
                begin
                    if (exp_reg[0])
                        acc_next = acc_prod[VAL_W-1:0];
                    sq_next  = sq_prod[VAL_W-1:0];
                    exp_next = exp_reg >> 1;
                end
            end
            A_DONE:
            begin
                state_next = A_IDLE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= A_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        fault_reg  <= fault_next;
        dvd_reg    <= dvd_next;
        dvs_reg    <= dvs_next;
        rem_reg    <= rem_next;
        neg_reg    <= neg_next;
        cnt_reg    <= cnt_next;
        acc_reg    <= acc_next;
        sq_reg     <= sq_next;
        exp_reg    <= exp_next;
    end

    assign rsp.done   = (state_reg == A_DONE);
    assign rsp.fault  = fault_reg;
    assign rsp.result = result_reg;

endmodule

// File: hdl/postfix_stack_evaluator_unit.sv
// postfix_stack_evaluator_unit: top level, operand stack memory and sequencer
// depends on pse_pkg and pse_alu
//
// channel  dir  signals                     content
// s        in   s_tvalid s_tready s_tdata   symbol [7:0], s_tlast = last
// m        out  m_tvalid m_tready m_tdata   value [7:0], status [9:8]
//
// a push is taken in the idle state; an operator + - * / ^ passes S_LOAD and S_CALC,
// all operators through the shared pse_alu and one registered stack memory read
// a last transaction then passes S_FINISH to load the output register
// s_tready is high only while the sequencer is idle; a pending result holds
// only the finish of the next expression until m_tready; no clearing pass after reset
`timescale 1ns / 1ps

module postfix_stack_evaluator_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [pse_pkg::SYM_W-1:0]         s_tdata,   // symbol
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pse_pkg::OUT_TDATA_W-1:0]   m_tdata    // value, status, zero fill
);
    import pse_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOAD   = 4'b0010,
        S_CALC   = 4'b0100,
        S_FINISH = 4'b1000
    } seq_state_t;

    seq_state_t             state_reg, state_next;
    logic [DEPTH_W-1:0]     depth_reg, depth_next;
    logic [STATUS_W-1:0]    err_reg, err_next;
    logic [VAL_W-1:0]       top_reg, top_next;
    logic                   last_reg, last_next;
    alu_op_t                op_reg, op_next;
    logic                   out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]       out_value_reg, out_value_next;
    logic [STATUS_W-1:0]    out_status_reg, out_status_next;

    logic [VAL_W-1:0]       stack_mem [STACK_ENTRIES];
    logic [VAL_W-1:0]       rd_data_reg;
    logic [ADDR_W-1:0]      rd_addr, wr_addr;
    logic [DEPTH_W-1:0]     depth_m1, depth_m2;
    logic                   wr_en;

    logic                   accept, is_op;
    alu_op_t                sym_op;
    alu_req_t               alu_req;
    alu_rsp_t               alu_rsp;
    logic [STATUS_W-1:0]    fin_status;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign depth_m1 = depth_reg - 1'b1;
    assign depth_m2 = depth_reg - 2'd2;
    assign rd_addr  = depth_m2[ADDR_W-1:0];
    assign wr_addr  = depth_m1[ADDR_W-1:0];

    always_comb
    begin
        is_op  = 1'b1;
        sym_op = OP_ADD;
        case (s_tdata)
            CHAR_PLUS:  sym_op = OP_ADD;
            CHAR_MINUS: sym_op = OP_SUB;
            CHAR_TIMES: sym_op = OP_MUL;
            CHAR_SLASH: sym_op = OP_DIV;
            CHAR_CARET: sym_op = OP_POW;
            default:    is_op  = 1'b0;
        endcase
    end

    always_comb
    begin
        if (err_reg != ST_OK)
            fin_status = err_reg;
        else if (depth_reg != DEPTH_W'(1))
            fin_status = ST_COUNT;
        else
            fin_status = ST_OK;
    end

    always_comb
    begin
        state_next      = state_reg;
        depth_next      = depth_reg;
        err_next        = err_reg;
        top_next        = top_reg;
        last_next       = last_reg;
        op_next         = op_reg;
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        wr_en           = 1'b0;
        alu_req.start   = 1'b0;
        alu_req.op      = op_reg;
        alu_req.lhs     = rd_data_reg;
        alu_req.rhs     = top_reg;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    last_next = s_tlast;
                    op_next   = sym_op;
                    if (s_tlast)
                        state_next = S_FINISH;
                    if (err_reg == ST_OK)
                    begin
                        if (is_op)
                        begin
                            if (depth_reg < DEPTH_W'(2))
                                err_next = ST_MISSING;
                            else
                                state_next = S_LOAD;
                        end
                        else if (depth_reg < DEPTH_W'(STACK_ENTRIES))
                        begin
                            wr_en      = (depth_reg != '0);
                            top_next   = s_tdata - CHAR_ZERO;
                            depth_next = depth_reg + 1'b1;
                        end
                    end
                end
            end
            S_LOAD:
            begin
                alu_req.start = 1'b1;
                state_next    = S_CALC;
            end
            S_CALC:
            begin
                if (alu_rsp.done)
                begin
                    if (alu_rsp.fault)
                    begin
                        err_next = ST_DIVZERO;
                    end
                    else
                    begin
                        top_next   = alu_rsp.result;
                        depth_next = depth_m1;
                    end
                    state_next = last_reg ? S_FINISH : S_IDLE;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = fin_status;
                    out_value_next  = (fin_status == ST_OK) ? top_reg : '0;
                    depth_next      = '0;
                    err_next        = ST_OK;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            stack_mem[wr_addr] <= top_reg;
        rd_data_reg <= stack_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg        <= top_next;
        last_reg       <= last_next;
        op_reg         <= op_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    pse_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - VAL_W - STATUS_W){1'b0}}, out_status_reg, out_value_reg};

endmodule
